// ===== hw/rtl/spma_pkg.sv =====
// ----------------------------------------------------------------------------
// spma_pkg: shared definitions of the shunt power monitor
// Widths, limits, register indexes, sequencer states and the divider
// request and response types used by the averaging block.
// ----------------------------------------------------------------------------
package spma_pkg;

	// window and value limits
	localparam int WINDOW_LEN   = 16;
	localparam int WARMUP_COUNT = 3;
	localparam int SAT_LIMIT    = 1000000;
	localparam int Q_FRAC       = 16;

	// field widths
	localparam int CODE_W  = 12;
	localparam int VAL_W   = 21;
	localparam int GAIN_W  = 32;
	localparam int POWER_W = 41;
	localparam int DIFF_W  = CODE_W + 1;

	// ring, count and running sum widths
	localparam int SLOT_W  = $clog2(WINDOW_LEN);
	localparam int CNT_W   = $clog2(WINDOW_LEN + 1);
	localparam int TOTAL_W = $clog2(WINDOW_LEN * SAT_LIMIT + 1) + 1;
	localparam int MAG_W   = TOTAL_W - 1;
	localparam int STEP_W  = $clog2(MAG_W + 1);

	// shared multiplier and scaling widths
	localparam int MUL_A_W = VAL_W;
	localparam int MUL_B_W = GAIN_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int RND_W   = PROD_W - Q_FRAC;
	localparam int SUM_W   = RND_W + 1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VOLT_GAIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_VOLT_OFFSET = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_GAIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_OFFSET  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CUR_ENABLE  = 3'd6;

	// reset values of the calibration registers
	localparam logic [GAIN_W-1:0]        VOLT_GAIN_RST = 32'd52818;
	localparam logic signed [GAIN_W-1:0] CUR_GAIN_RST  = 32'sd105636;

	typedef logic [CODE_W-1:0]         code_t;
	typedef logic signed [VAL_W-1:0]   val_t;
	typedef logic signed [POWER_W-1:0] power_t;

	// one ring entry holds both scaled samples
	typedef struct packed {
		val_t volt;
		val_t curr;
	} ring_word_t;

	typedef struct packed {
		logic                      start;
		logic signed [TOTAL_W-1:0] dividend;
		logic [CNT_W-1:0]          divisor;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [MAG_W:0]   quotient;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MULV,
		S_MULC,
		S_CUR,
		S_SUM,
		S_DIVV,
		S_WAITV,
		S_DIVC,
		S_WAITC,
		S_PWR,
		S_OUT
	} state_t;

	// clamp a widened sum to the +-SAT_LIMIT range
	function automatic val_t sat_val(logic signed [SUM_W-1:0] x);
		val_t r;
		if (x > SUM_W'(SAT_LIMIT)) begin
			r = VAL_W'(SAT_LIMIT);
		end else if (x < -SUM_W'(SAT_LIMIT)) begin
			r = -VAL_W'(SAT_LIMIT);
		end else begin
			r = VAL_W'(x);
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/spma_stream_if.sv =====
// ----------------------------------------------------------------------------
// spma_stream_if: sample and result channels of the power monitor
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface spma_sample_if
	import spma_pkg::*;
();
	logic  valid;
	logic  ready;
	code_t adc_code;

	modport source(output valid, output adc_code, input ready);
	modport sink(input valid, input adc_code, output ready);
endinterface

interface spma_result_if
	import spma_pkg::*;
();
	logic   valid;
	logic   ready;
	val_t   avg_voltage_mv;
	val_t   avg_current_ma;
	power_t power_uw;
	logic   window_full;

	modport source(output valid, output avg_voltage_mv, output avg_current_ma,
		output power_uw, output window_full, input ready);
	modport sink(input valid, input avg_voltage_mv, input avg_current_ma,
		input power_uw, input window_full, output ready);
endinterface

// ===== hw/rtl/spma_div.sv =====
// ----------------------------------------------------------------------------
// spma_div: serial signed divider by the window fill count
// Restoring division of a running sum by a small unsigned count, one
// quotient bit per cycle, quotient truncated toward zero.
// ----------------------------------------------------------------------------
module spma_div import spma_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic [CNT_W:0]       rem_q;
	logic [MAG_W-1:0]     quo_q;
	logic [CNT_W-1:0]     dvs_q;
	logic                 neg_q;
	logic [STEP_W-1:0]    step_q;
	logic                 done_q;

	logic [TOTAL_W-1:0]   mag_full;
	logic [CNT_W:0]       rem_shift;
	logic [CNT_W+1:0]     trial;
	logic signed [MAG_W:0] quo_ext;

	// magnitude of the dividend
	assign mag_full = req.dividend[TOTAL_W-1] ? TOTAL_W'(-req.dividend)
		: TOTAL_W'(req.dividend);

	// shift one dividend bit into the remainder and try the subtract
	assign rem_shift = {rem_q[CNT_W-1:0], quo_q[MAG_W-1]};
	assign trial     = {1'b0, rem_shift} - {2'b00, dvs_q};

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else if (req.start) begin
			step_q <= STEP_W'(MAG_W);
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == STEP_W'(1));
			if (step_q != '0) begin
				step_q <= step_q - STEP_W'(1);
			end
		end
	end

	// remainder and quotient shift register
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= mag_full[MAG_W-1:0];
			dvs_q <= req.divisor;
			neg_q <= req.dividend[TOTAL_W-1];
		end else if (step_q != '0) begin
			if (!trial[CNT_W+1]) begin
				rem_q <= trial[CNT_W:0];
			end else begin
				rem_q <= rem_shift;
			end
			quo_q <= {quo_q[MAG_W-2:0], ~trial[CNT_W+1]};
		end
	end

	// apply the sign of the dividend
	assign quo_ext      = signed'({1'b0, quo_q});
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? -quo_ext : quo_ext;

	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> step_q == '0)
		else $error("divider done while steps remain");

	assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_W'(1) && !req.start) |=> done_q)
		else $error("divider missed its done pulse");

	assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> step_q == STEP_W'(MAG_W))
		else $error("divider did not load its step count");

endmodule

// ===== hw/rtl/shunt_power_monitor_average.sv =====
// ----------------------------------------------------------------------------
// shunt_power_monitor_average: scaled voltage/current with boxcar averaging
// Scales each converter code to millivolts and milliamps, keeps both in a
// ring with running sums, and reports the window averages and their power.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake       payload
//  sample    in   valid / ready   adc_code
//  result    out  valid / ready   avg_voltage_mv, avg_current_ma, power_uw,
//                                 window_full
//  cfg       in   cfg_we          cfg_index, cfg_data
//
//  An enabled sample passes through the sequencer states in order: one
//  shared multiplier handles voltage, current and power, then the serial
//  divider runs once per average, one bit a cycle. During warm-up the
//  divider is skipped. With the block disabled a sample is taken and dropped.
//  Reset clears the ring logically through the wrap flag; no clearing pass.
//  A waiting result holds the sequencer in its last state; a new sample
//  is taken as soon as the result is moved to the output register.
//
module shunt_power_monitor_average import spma_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	spma_sample_if.sink           sample,
	spma_result_if.source         result
);

	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (Q_FRAC - 1);

	// configuration registers
	logic                      cfg_enable_q;
	logic [GAIN_W-1:0]         cfg_vgain_q;
	val_t                      cfg_voff_q;
	code_t                     cfg_bias_q;
	logic signed [GAIN_W-1:0]  cfg_cgain_q;
	val_t                      cfg_coff_q;
	logic                      cfg_cur_en_q;

	// sequencer and datapath
	state_t                    state_q, state_d;
	code_t                     code_q;
	logic signed [PROD_W-1:0]  prod_q;
	val_t                      v_q, c_q;
	val_t                      first_v_q, first_c_q;
	val_t                      av_q, ac_q;
	logic [SLOT_W-1:0]         slot_q;
	logic                      ring_wrapped_q;
	logic signed [TOTAL_W-1:0] volt_total_q, curr_total_q;
	logic                      warm_q;
	logic [CNT_W-1:0]          count_q;

	ring_word_t                ring_mem [WINDOW_LEN];
	ring_word_t                ring_rd_q;

	// output register
	logic                      out_valid_q;
	val_t                      out_v_q, out_c_q;
	power_t                    out_p_q;
	logic                      out_full_q;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [PROD_W-1:0]  prod_rnd;
	logic signed [SUM_W-1:0]   scaled_sum;
	logic signed [DIFF_W-1:0]  code_diff;
	logic                      in_xfer, out_xfer, out_load;
	logic [SLOT_W-1:0]         slot_nxt;
	logic                      wrap_nxt;
	ring_word_t                ring_old;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	assign in_xfer  = sample.valid && sample.ready;
	assign out_xfer = result.valid && result.ready;
	assign out_load = (state_q == S_OUT) && (!out_valid_q || result.ready);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_enable_q <= 1'b0;
			cfg_vgain_q  <= VOLT_GAIN_RST;
			cfg_voff_q   <= '0;
			cfg_bias_q   <= '0;
			cfg_cgain_q  <= CUR_GAIN_RST;
			cfg_coff_q   <= '0;
			cfg_cur_en_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE:      cfg_enable_q <= cfg_data[0];
				REG_VOLT_GAIN:   cfg_vgain_q  <= cfg_data[GAIN_W-1:0];
				REG_VOLT_OFFSET: cfg_voff_q   <= signed'(cfg_data[VAL_W-1:0]);
				REG_BIAS:        cfg_bias_q   <= cfg_data[CODE_W-1:0];
				REG_CUR_GAIN:    cfg_cgain_q  <= signed'(cfg_data[GAIN_W-1:0]);
				REG_CUR_OFFSET:  cfg_coff_q   <= signed'(cfg_data[VAL_W-1:0]);
				REG_CUR_ENABLE:  cfg_cur_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_xfer && cfg_enable_q) state_d = S_MULV;
			S_MULV:  state_d = S_MULC;
			S_MULC:  state_d = S_CUR;
			S_CUR:   state_d = S_SUM;
			S_SUM:   state_d = S_DIVV;
			S_DIVV:  state_d = warm_q ? S_PWR : S_WAITV;
			S_WAITV: if (div_rsp.done) state_d = S_DIVC;
			S_DIVC:  state_d = S_WAITC;
			S_WAITC: if (div_rsp.done) state_d = S_PWR;
			S_PWR:   state_d = S_OUT;
			S_OUT:   if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs: multiplier operands, divider request, ready
	always_comb begin
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = volt_total_q;
		div_req.divisor  = count_q;
		sample.ready     = 1'b0;
		unique case (state_q)
			S_IDLE: sample.ready = 1'b1;
			S_MULV: begin
				mul_a = MUL_A_W'({1'b0, code_q});
				mul_b = MUL_B_W'({1'b0, cfg_vgain_q});
			end
			S_MULC: begin
				mul_a = MUL_A_W'(code_diff);
				mul_b = MUL_B_W'(cfg_cgain_q);
			end
			S_DIVV: div_req.start = !warm_q;
			S_DIVC: begin
				div_req.start    = 1'b1;
				div_req.dividend = curr_total_q;
			end
			S_PWR: begin
				mul_a = av_q;
				mul_b = MUL_B_W'(ac_q);
			end
			default: begin
			end
		endcase
	end

	assign code_diff = signed'({1'b0, code_q}) - signed'({1'b0, cfg_bias_q});

	// shared multiplier
	assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

	// round the Q16 product to nearest and add the selected offset
	assign prod_rnd   = prod_q + RND_HALF;
	assign scaled_sum = SUM_W'(signed'(prod_rnd[PROD_W-1:Q_FRAC]))
		+ SUM_W'((state_q == S_MULC) ? cfg_voff_q : cfg_coff_q);

	// ring position after this write
	assign slot_nxt = (slot_q == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_q + SLOT_W'(1);
	assign wrap_nxt = ring_wrapped_q || (slot_nxt == '0);

	// entries never written read as zero
	assign ring_old = ring_wrapped_q ? ring_rd_q : '0;

	// ring state and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			slot_q         <= '0;
			ring_wrapped_q <= 1'b0;
			volt_total_q   <= '0;
			curr_total_q   <= '0;
			warm_q         <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_SUM) begin
				volt_total_q   <= volt_total_q - TOTAL_W'(ring_old.volt) + TOTAL_W'(v_q);
				curr_total_q   <= curr_total_q - TOTAL_W'(ring_old.curr) + TOTAL_W'(c_q);
				slot_q         <= slot_nxt;
				ring_wrapped_q <= wrap_nxt;
				warm_q         <= !wrap_nxt && (slot_nxt < SLOT_W'(WARMUP_COUNT));
			end
		end
	end

	// ring memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (state_q == S_SUM) begin
			ring_mem[slot_q] <= '{volt: v_q, curr: c_q};
		end
		ring_rd_q <= ring_mem[slot_q];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			code_q <= sample.adc_code;
		end
		if (state_q == S_MULV || state_q == S_MULC || state_q == S_PWR) begin
			prod_q <= mul_p;
		end
		if (state_q == S_MULC) begin
			v_q <= sat_val(scaled_sum);
		end
		if (state_q == S_CUR) begin
			c_q <= cfg_cur_en_q ? sat_val(scaled_sum) : '0;
		end
		if (state_q == S_SUM) begin
			count_q <= wrap_nxt ? CNT_W'(WINDOW_LEN) : CNT_W'(slot_nxt);
			if (slot_q == '0) begin
				first_v_q <= v_q;
				first_c_q <= c_q;
			end
		end
		// warm-up: hold the first sample as the average
		if (state_q == S_DIVV && warm_q) begin
			av_q <= first_v_q;
			ac_q <= first_c_q;
		end
		if (state_q == S_WAITV && div_rsp.done) begin
			av_q <= VAL_W'(div_rsp.quotient);
		end
		if (state_q == S_WAITC && div_rsp.done) begin
			ac_q <= VAL_W'(div_rsp.quotient);
		end
		if (out_load) begin
			out_v_q    <= av_q;
			out_c_q    <= ac_q;
			out_p_q    <= prod_q[POWER_W-1:0];
			out_full_q <= ring_wrapped_q;
		end
	end

	// result valid: set on load, drop after transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	spma_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign result.valid          = out_valid_q;
	assign result.avg_voltage_mv = out_v_q;
	assign result.avg_current_ma = out_c_q;
	assign result.power_uw       = out_p_q;
	assign result.window_full    = out_full_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(ring_wrapped_q))
		else $error("ring wrap flag cleared after being set");

	assert property (@(posedge clk) disable iff (!arst_n)
		warm_q |-> !ring_wrapped_q)
		else $error("warm-up flagged after the ring wrapped");

	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_WAITV || state_q == S_WAITC))
		else $error("divider finished outside a wait state");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && !cfg_enable_q) |=> state_q == S_IDLE)
		else $error("sample taken while disabled");

	assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(WINDOW_LEN - 1))
		else $error("write slot beyond the window");

endmodule

// ===== bench/shunt_power_monitor_average_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shunt_power_monitor_average_tb: self-checking bench of the averaging monitor
// Drives converter codes through the sample channel and calibration values
// through the register port. A built-in predictor tracks the scaling, the
// sample rings and the running sums. Every result transfer is checked against
// the oldest predicted reading. A short directed table comes first. It is
// followed by random phases that rewrite the registers while the block is
// idle. Both channels idle at random.
// ----------------------------------------------------------------------------
module shunt_power_monitor_average_tb;
	import spma_pkg::*;

	localparam int RANDOM_ITEMS   = 1350;
	localparam int SETTLE_CYCLES  = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_IDLE       = 10;

	// index past the register file; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef struct packed {
		val_t   volt;
		val_t   curr;
		power_t power;
		logic   full;
	} reading_t;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] value;
		logic                  typed;
		reading_t              want;
	} plan_row_t;

	localparam reading_t NO_READING  = '0;
	localparam reading_t SAT_READING = '{val_t'(SAT_LIMIT), val_t'(SAT_LIMIT),
		41'sd1000000000000, 1'b0};

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	spma_sample_if sample_ch();
	spma_result_if result_ch();

	shunt_power_monitor_average DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample_ch),
		.result    (result_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// calibration copy held by the predictor
	bit          mon_enable  = 1'b0;
	logic [31:0] volt_gain   = VOLT_GAIN_RST;
	int          volt_offset = 0;
	logic [11:0] bias_code   = '0;
	int          cur_gain    = CUR_GAIN_RST;
	int          cur_offset  = 0;
	bit          cur_enable  = 1'b1;

	// ring and running sums held by the predictor
	int                volt_ring [WINDOW_LEN] = '{default: 0};
	int                curr_ring [WINDOW_LEN] = '{default: 0};
	logic [SLOT_W-1:0] fill_slot  = '0;
	bit                ring_full  = 1'b0;
	int                volt_total = 0;
	int                curr_total = 0;

	reading_t pending_readings[$];
	int       fail_count     = 0;
	int       stall_cycles   = 0;
	bit       source_quiet   = 1'b0;
	bit       dropped_sample = 1'b0;

	plan_row_t directed_plan[$] = '{
		'{ROW_SAMPLE, REG_SPARE,       32'd100,       1'b0, NO_READING},
		'{ROW_WRITE,  REG_ENABLE,      32'd1,         1'b0, NO_READING},
		'{ROW_WRITE,  REG_VOLT_GAIN,   32'hFFFF_FFFF, 1'b0, NO_READING},
		'{ROW_WRITE,  REG_CUR_GAIN,    32'h7FFF_FFFF, 1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd4095,      1'b1, SAT_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd0,         1'b1, SAT_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd0,         1'b0, NO_READING},
		'{ROW_WRITE,  REG_CUR_GAIN,    32'h8000_0000, 1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd4095,      1'b0, NO_READING},
		'{ROW_WRITE,  REG_BIAS,        32'h0000_0FFF, 1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd0,         1'b0, NO_READING},
		'{ROW_WRITE,  REG_VOLT_OFFSET, 32'hFFF0_0000, 1'b0, NO_READING},
		'{ROW_WRITE,  REG_VOLT_GAIN,   32'h0000_0000, 1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd4095,      1'b0, NO_READING},
		'{ROW_WRITE,  REG_VOLT_OFFSET, 32'h000F_FFFF, 1'b0, NO_READING},
		'{ROW_WRITE,  REG_CUR_OFFSET,  32'h0010_0000, 1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd4095,      1'b0, NO_READING},
		'{ROW_WRITE,  REG_CUR_ENABLE,  32'd0,         1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd2048,      1'b0, NO_READING},
		'{ROW_WRITE,  REG_SPARE,       32'hFFFF_FFFF, 1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd4095,      1'b0, NO_READING},
		'{ROW_WRITE,  REG_CUR_ENABLE,  32'd1,         1'b0, NO_READING},
		'{ROW_WRITE,  REG_CUR_OFFSET,  32'd0,         1'b0, NO_READING},
		'{ROW_WRITE,  REG_VOLT_OFFSET, 32'd0,         1'b0, NO_READING},
		'{ROW_WRITE,  REG_BIAS,        32'd0,         1'b0, NO_READING},
		'{ROW_WRITE,  REG_VOLT_GAIN,   32'h0000_8000, 1'b0, NO_READING},
		'{ROW_WRITE,  REG_CUR_GAIN,    32'hFFFF_8000, 1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd1,         1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd4095,      1'b0, NO_READING},
		'{ROW_WRITE,  REG_ENABLE,      32'd0,         1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd7,         1'b0, NO_READING},
		'{ROW_WRITE,  REG_ENABLE,      32'd1,         1'b0, NO_READING},
		'{ROW_SAMPLE, REG_SPARE,       32'd3,         1'b0, NO_READING}
	};

	// clamp a scaled sample to the +-1000 V / +-1000 A style limit
	function automatic int clamp_sample(longint x);
		if (x > SAT_LIMIT) begin
			return SAT_LIMIT;
		end else if (x < -SAT_LIMIT) begin
			return -SAT_LIMIT;
		end
		return int'(x);
	endfunction

	// mirror one register write
	function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_ENABLE:      mon_enable  = data[0];
			REG_VOLT_GAIN:   volt_gain   = data;
			REG_VOLT_OFFSET: volt_offset = {{11{data[20]}}, data[20:0]};
			REG_BIAS:        bias_code   = data[11:0];
			REG_CUR_GAIN:    cur_gain    = $signed(data);
			REG_CUR_OFFSET:  cur_offset  = {{11{data[20]}}, data[20:0]};
			REG_CUR_ENABLE:  cur_enable  = data[0];
			default: ;
		endcase
	endfunction

	// scale one code, update the rings and form the averaged reading
	function automatic bit average_reading(code_t code, output reading_t r);
		longint volt_prod, curr_prod;
		int     volt_mv, curr_ma, avg_v, avg_c, count;
		r = '0;
		if (!mon_enable) begin
			return 1'b0;
		end
		volt_prod = longint'(code) * longint'(volt_gain);
		volt_mv   = clamp_sample(((volt_prod + 32768) >>> Q_FRAC) + volt_offset);
		if (cur_enable) begin
			curr_prod = (longint'(code) - longint'(bias_code)) * longint'(cur_gain);
			curr_ma   = clamp_sample(((curr_prod + 32768) >>> Q_FRAC) + cur_offset);
		end else begin
			curr_ma = 0;
		end
		volt_total = volt_total - volt_ring[fill_slot] + volt_mv;
		curr_total = curr_total - curr_ring[fill_slot] + curr_ma;
		volt_ring[fill_slot] = volt_mv;
		curr_ring[fill_slot] = curr_ma;
		fill_slot = fill_slot + 1'b1;
		if (fill_slot == 0) begin
			ring_full = 1'b1;
		end
		// warm-up reports the first sample as it is
		if (!ring_full && fill_slot < WARMUP_COUNT) begin
			avg_v = volt_ring[0];
			avg_c = curr_ring[0];
		end else begin
			count = ring_full ? WINDOW_LEN : int'(fill_slot);
			avg_v = volt_total / count;
			avg_c = curr_total / count;
		end
		r.volt  = val_t'(avg_v);
		r.curr  = val_t'(avg_c);
		r.power = power_t'(longint'(avg_v) * longint'(avg_c));
		r.full  = ring_full;
		return 1'b1;
	endfunction

	// draw a register value, extremes included
	function automatic logic [CFG_DATA_W-1:0] random_setting(logic [CFG_IDX_W-1:0] idx);
		logic [CFG_DATA_W-1:0] d;
		d = $urandom();
		case (idx)
			REG_ENABLE:     d[0] = ($urandom_range(0, 7) != 0);
			REG_CUR_ENABLE: d[0] = ($urandom_range(0, 5) != 0);
			REG_VOLT_GAIN: begin
				case ($urandom_range(0, 9))
					0: d = '0;
					1: d = '1;
					2: ;
					default: d = $urandom_range(20000, 120000);
				endcase
			end
			REG_VOLT_OFFSET, REG_CUR_OFFSET: begin
				case ($urandom_range(0, 9))
					0: d = 32'hFFF0_0000;
					1: d = 32'h000F_FFFF;
					2: d = SAT_LIMIT;
					3: d = -SAT_LIMIT;
					4: ;
					default: d = int'($urandom_range(0, 4000)) - 2000;
				endcase
			end
			REG_CUR_GAIN: begin
				case ($urandom_range(0, 9))
					0: d = 32'h8000_0000;
					1: d = 32'h7FFF_FFFF;
					2: d = '0;
					3: ;
					default: d = int'($urandom_range(0, 400000)) - 200000;
				endcase
			end
			default: ;
		endcase
		return d;
	endfunction

	// offer one code and record its reading once the transfer happens
	task automatic send_code(code_t code, bit typed, reading_t want);
		int       gap;
		reading_t r;
		gap = source_quiet ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid    <= 1'b1;
		sample_ch.adc_code <= code;
		do @(posedge clk); while (!sample_ch.ready);
		if (average_reading(code, r)) begin
			pending_readings.push_back(typed ? want : r);
		end else begin
			dropped_sample = 1'b1;
		end
	endtask

	// write a register once the block has gone idle
	task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		sample_ch.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		if (dropped_sample) begin
			repeat (SETTLE_CYCLES) @(posedge clk);
			dropped_sample = 1'b0;
		end
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		apply_setting(idx, data);
	endtask

	// stimulus: directed table, then random phases
	initial begin
		code_t code;
		int    phase_len;
		int    random_items;
		logic [CFG_IDX_W-1:0] idx;
		random_items = 0;
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= REG_ENABLE;
		cfg_data           <= '0;
		sample_ch.valid    <= 1'b0;
		sample_ch.adc_code <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_WRITE) begin
				write_setting(directed_plan[i].idx, directed_plan[i].value);
			end else begin
				send_code(directed_plan[i].value[CODE_W-1:0], directed_plan[i].typed,
					directed_plan[i].want);
			end
		end

		while (random_items < RANDOM_ITEMS) begin
			// reconfigure: enable every phase, the rest now and then
			for (int r = REG_ENABLE; r <= REG_SPARE; r++) begin
				idx = CFG_IDX_W'(r);
				if (idx == REG_ENABLE || $urandom_range(0, 2) == 0) begin
					write_setting(idx, random_setting(idx));
				end
			end
			phase_len    = mon_enable ? $urandom_range(4, 60) : $urandom_range(2, 8);
			source_quiet = ($urandom_range(0, 3) == 0);
			repeat (phase_len) begin
				case ($urandom_range(0, 7))
					0: code = '0;
					1: code = '1;
					default: code = code_t'($urandom());
				endcase
				send_code(code, 1'b0, NO_READING);
				if (mon_enable) begin
					random_items++;
				end
			end
		end

		// drain, then give the block time to show anything extra
		sample_ch.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// result side: random stalls, with quiet stretches
	initial begin
		int  stall;
		int  stretch_left;
		bit  sink_quiet;
		stretch_left = 0;
		sink_quiet   = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (stretch_left == 0) begin
				stretch_left = $urandom_range(10, 60);
				sink_quiet   = ($urandom_range(0, 2) == 0);
			end
			stretch_left--;
			stall = sink_quiet ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	// compare each result transfer with the oldest predicted reading
	always @(posedge clk) begin
		reading_t got, want;
		if (result_ch.valid && result_ch.ready) begin
			got = '{result_ch.avg_voltage_mv, result_ch.avg_current_ma,
				result_ch.power_uw, result_ch.window_full};
			if (pending_readings.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, got mv %0d ma %0d uw %0d full %0b",
					$time, got.volt, got.curr, got.power, got.full);
			end else begin
				want = pending_readings.pop_front();
				if (got !== want) begin
					fail_count++;
					$display({"%0t: mismatch, expected mv %0d ma %0d uw %0d full %0b,",
						" got mv %0d ma %0d uw %0d full %0b"},
						$time, want.volt, want.curr, want.power, want.full,
						got.volt, got.curr, got.power, got.full);
				end
			end
		end
	end

	// abort when neither channel moves for too long
	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("TEST FAILED");
			$finish;
		end
	end

endmodule
